[rtl/filtered_mppt_duty_tracker_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the filtered MPPT duty tracker
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef FILTERED_MPPT_DUTY_TRACKER_MACROS_SVH
`define FILTERED_MPPT_DUTY_TRACKER_MACROS_SVH

// Same-cycle implication.
`define FMDT_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FMDT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/fmdt_pkg.sv]
// ---------------------------------------------------------------------------
// fmdt_pkg
// Types, widths and constants shared by the duty tracker modules.
// ---------------------------------------------------------------------------
package fmdt_pkg;

  localparam int VOLTAGE_W = 12;
  localparam int CURRENT_W = 12;
  localparam int DUTY_W    = 17;
  localparam int STEP_W    = 16;

  // Step product: gap magnitude times Q0.16 fraction plus rounding half.
  localparam int PROD_W = DUTY_W + STEP_W;
  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (STEP_W - 1);
  localparam logic [DUTY_W-1:0] DUTY_MAX   = '1;

  localparam int MEDIUM_WINDOW_DEFAULT = 512;
  localparam int FAST_WINDOW_DEFAULT   = 128;
  localparam int SAMPLE_BITS_DEFAULT   = 12;

  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  localparam logic [STEP_W-1:0] STEP_FRACTION_RESET = 16'd33;
  localparam logic [DUTY_W-1:0] DUTY_CEILING_RESET  = 17'd79495;

  typedef enum logic [0:0] {
    REG_STEP_FRACTION = 1'b0,
    REG_DUTY_CEILING  = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [VOLTAGE_W-1:0] voltage_sample;
    logic [CURRENT_W-1:0] current_sample;
    logic [DUTY_W-1:0]    duty_previous;
  } sample_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty_next;
    logic              direction_up;
    logic              reversed_now;
  } result_t;

  typedef struct packed {
    logic [STEP_W-1:0] step_fraction;
    logic [DUTY_W-1:0] duty_ceiling;
  } cfg_t;

  typedef struct packed {
    logic going_up;
    logic disarmed;
  } state_t;

endpackage

[rtl/filtered_mppt_duty_tracker.sv]
// ---------------------------------------------------------------------------
// filtered_mppt_duty_tracker: perturb-and-observe duty tracker on filtered power
// Pipeline: a sample beat passes through stages A, B, C and D into the result register.
// Throughput: one beat per cycle unless the receiver stalls, set by the history's one write and two reads.
// Reset: control cleared at once; a fill count masks the history, no clear pass.
// ---------------------------------------------------------------------------
`include "filtered_mppt_duty_tracker_macros.svh"

module filtered_mppt_duty_tracker #(
  parameter int MEDIUM_WINDOW = fmdt_pkg::MEDIUM_WINDOW_DEFAULT,
  parameter int FAST_WINDOW   = fmdt_pkg::FAST_WINDOW_DEFAULT,
  parameter int SAMPLE_BITS   = fmdt_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [fmdt_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [fmdt_pkg::APB_DATA_W-1:0] pwdata,
  output logic [fmdt_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready,
  input  logic                            sample_valid,
  output logic                            sample_stall,
  input  fmdt_pkg::sample_t               sample,
  output logic                            result_valid,
  input  logic                            result_stall,
  output fmdt_pkg::result_t               result
);

  // Widths follow the windows and the sample width. The history holds the
  // larger of the two windows, and each running sum is wide enough for a
  // full window of maximum powers.
  localparam int SAMPLE_W = (SAMPLE_BITS < fmdt_pkg::VOLTAGE_W) ?
                            SAMPLE_BITS : fmdt_pkg::VOLTAGE_W;
  localparam int POWER_W  = 2 * SAMPLE_W;
  localparam int DEPTH    = (MEDIUM_WINDOW > FAST_WINDOW) ? MEDIUM_WINDOW : FAST_WINDOW;
  localparam int AW       = $clog2(DEPTH);
  localparam int MSUM_W   = POWER_W + $clog2(MEDIUM_WINDOW);
  localparam int FSUM_W   = POWER_W + $clog2(FAST_WINDOW);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  fmdt_pkg::cfg_t   cfg;
  fmdt_pkg::state_t dstate;

  logic                        hist_re;
  logic [AW-1:0]               hist_raddr_med;
  logic [AW-1:0]               hist_raddr_fast;
  logic [POWER_W-1:0]          hist_rdata_med;
  logic [POWER_W-1:0]          hist_rdata_fast;
  logic                        hist_we;
  logic [AW-1:0]               hist_waddr;
  logic [POWER_W-1:0]          hist_wdata;

  logic                        sum_valid;
  logic                        sum_ready;
  logic [fmdt_pkg::DUTY_W-1:0] sum_prev;
  logic [MSUM_W-1:0]           sum_med;
  logic [FSUM_W-1:0]           sum_fast;

  // Configuration registers. Writes are expected only while the pipeline
  // is empty, so the step and ceiling seen by the datapath never change
  // under an item in flight.
  fmdt_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Power history ring. The filter reads the two samples leaving the
  // windows as an item moves into its second stage and writes the new
  // power as the item leaves; a read and write to the same slot in the
  // same cycle is forwarded inside the memory.
  fmdt_history_mem #(
    .DEPTH (DEPTH),
    .WIDTH (POWER_W)
  ) u_history_mem (
    .clk     (clk),
    .we      (hist_we),
    .waddr   (hist_waddr),
    .wdata   (hist_wdata),
    .re      (hist_re),
    .raddr_a (hist_raddr_med),
    .raddr_b (hist_raddr_fast),
    .rdata_a (hist_rdata_med),
    .rdata_b (hist_rdata_fast)
  );

  // Front half: input register, power product, and the running sums of
  // both windows, each updated by one add and one subtract per beat.
  fmdt_filter #(
    .MEDIUM_WINDOW (MEDIUM_WINDOW),
    .FAST_WINDOW   (FAST_WINDOW),
    .SAMPLE_BITS   (SAMPLE_BITS)
  ) u_filter (
    .clk             (clk),
    .rst             (rst),
    .sample_valid    (sample_valid),
    .sample_stall    (sample_stall),
    .sample          (sample),
    .hist_re         (hist_re),
    .hist_raddr_med  (hist_raddr_med),
    .hist_raddr_fast (hist_raddr_fast),
    .hist_rdata_med  (hist_rdata_med),
    .hist_rdata_fast (hist_rdata_fast),
    .hist_we         (hist_we),
    .hist_waddr      (hist_waddr),
    .hist_wdata      (hist_wdata),
    .sum_valid       (sum_valid),
    .sum_ready       (sum_ready),
    .sum_prev        (sum_prev),
    .sum_med         (sum_med),
    .sum_fast        (sum_fast)
  );

  // Back half: the averages are compared by cross-multiplication, the
  // arm/disarm state decides the direction, and the duty moves by the
  // rounded step fraction of the gap to the ceiling, saturated to range.
  // The result register lets a new beat enter while a result waits.
  fmdt_decide #(
    .MEDIUM_WINDOW (MEDIUM_WINDOW),
    .FAST_WINDOW   (FAST_WINDOW),
    .SAMPLE_BITS   (SAMPLE_BITS)
  ) u_decide (
    .clk          (clk),
    .rst          (rst),
    .sum_valid    (sum_valid),
    .sum_ready    (sum_ready),
    .sum_prev     (sum_prev),
    .sum_med      (sum_med),
    .sum_fast     (sum_fast),
    .cfg          (cfg),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .dstate       (dstate)
  );

  // Disarming happens only together with a direction flip.
  `FMDT_ASSERT_IMPLIES(a_disarm_flips, $rose(dstate.disarmed), dstate.going_up != $past(dstate.going_up), "disarm without a direction flip")
  // A direction change always leaves the block disarmed.
  `FMDT_ASSERT_IMPLIES(a_flip_disarms, dstate.going_up != $past(dstate.going_up), dstate.disarmed, "direction flipped but block still armed")
  // History addresses stay inside the ring.
  `FMDT_ASSERT_IMPLIES(a_hist_range, hist_we || hist_re, hist_waddr <= LAST_ADDR && hist_raddr_med <= LAST_ADDR && hist_raddr_fast <= LAST_ADDR, "history address out of range")
  // A read of the slot being written returns the new power.
  `FMDT_ASSERT_NEXT(a_hist_forward, hist_we && hist_re && hist_waddr == hist_raddr_fast, hist_rdata_fast == $past(hist_wdata), "history write not forwarded to read")

endmodule

[rtl/fmdt_cfg_regs.sv]
// ---------------------------------------------------------------------------
// fmdt_cfg_regs
// APB register file holding the step fraction and the duty ceiling.
// ---------------------------------------------------------------------------
module fmdt_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [fmdt_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [fmdt_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [fmdt_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  output fmdt_pkg::cfg_t                      cfg
);

  logic                 wr_en;
  fmdt_pkg::reg_index_t idx;

  // Registers sit on word boundaries; the word index is the top address bit.
  assign idx    = fmdt_pkg::reg_index_t'(paddr[fmdt_pkg::APB_ADDR_W-1]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_fraction <= fmdt_pkg::STEP_FRACTION_RESET;
      cfg.duty_ceiling  <= fmdt_pkg::DUTY_CEILING_RESET;
    end else if (wr_en) begin
      unique case (idx)
        fmdt_pkg::REG_STEP_FRACTION: begin
          cfg.step_fraction <= pwdata[fmdt_pkg::STEP_W-1:0];
        end
        fmdt_pkg::REG_DUTY_CEILING: begin
          cfg.duty_ceiling <= pwdata[fmdt_pkg::DUTY_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      fmdt_pkg::REG_STEP_FRACTION: prdata = fmdt_pkg::APB_DATA_W'(cfg.step_fraction);
      fmdt_pkg::REG_DUTY_CEILING:  prdata = fmdt_pkg::APB_DATA_W'(cfg.duty_ceiling);
      default:                     prdata = '0;
    endcase
  end

endmodule

[rtl/fmdt_history_mem.sv]
// ---------------------------------------------------------------------------
// fmdt_history_mem
// Power history ring: one write port and two registered read ports.
// ---------------------------------------------------------------------------
module fmdt_history_mem #(
  parameter int DEPTH = fmdt_pkg::MEDIUM_WINDOW_DEFAULT,
  parameter int WIDTH = 2 * fmdt_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // A read that hits the entry written at the same edge returns the new data.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= (we && (waddr == raddr_a)) ? wdata : mem[raddr_a];
      rdata_b <= (we && (waddr == raddr_b)) ? wdata : mem[raddr_b];
    end
  end

endmodule

[rtl/fmdt_filter.sv]
// ---------------------------------------------------------------------------
// fmdt_filter
// Input register, power product, history access and running window sums.
// ---------------------------------------------------------------------------
module fmdt_filter #(
  parameter int MEDIUM_WINDOW = fmdt_pkg::MEDIUM_WINDOW_DEFAULT,
  parameter int FAST_WINDOW   = fmdt_pkg::FAST_WINDOW_DEFAULT,
  parameter int SAMPLE_BITS   = fmdt_pkg::SAMPLE_BITS_DEFAULT,
  localparam int SAMPLE_W = (SAMPLE_BITS < fmdt_pkg::VOLTAGE_W) ?
                            SAMPLE_BITS : fmdt_pkg::VOLTAGE_W,
  localparam int POWER_W  = 2 * SAMPLE_W,
  localparam int DEPTH    = (MEDIUM_WINDOW > FAST_WINDOW) ? MEDIUM_WINDOW : FAST_WINDOW,
  localparam int AW       = $clog2(DEPTH),
  localparam int MSUM_W   = POWER_W + $clog2(MEDIUM_WINDOW),
  localparam int FSUM_W   = POWER_W + $clog2(FAST_WINDOW)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          sample_valid,
  output logic                          sample_stall,
  input  fmdt_pkg::sample_t             sample,
  output logic                          hist_re,
  output logic [AW-1:0]                 hist_raddr_med,
  output logic [AW-1:0]                 hist_raddr_fast,
  input  logic [POWER_W-1:0]            hist_rdata_med,
  input  logic [POWER_W-1:0]            hist_rdata_fast,
  output logic                          hist_we,
  output logic [AW-1:0]                 hist_waddr,
  output logic [POWER_W-1:0]            hist_wdata,
  output logic                          sum_valid,
  input  logic                          sum_ready,
  output logic [fmdt_pkg::DUTY_W-1:0]   sum_prev,
  output logic [MSUM_W-1:0]             sum_med,
  output logic [FSUM_W-1:0]             sum_fast
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [AW:0]      DEPTH_X  = (AW+1)'(DEPTH);
  localparam logic [AW:0]      MED_OFS  = (AW+1)'(DEPTH - MEDIUM_WINDOW);
  localparam logic [AW:0]      FAST_OFS = (AW+1)'(DEPTH - FAST_WINDOW);
  localparam logic [AW-1:0]    LAST     = AW'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL     = CNT_W'(DEPTH);

  // Stage A: registered input item.
  logic                        a_valid;
  logic [SAMPLE_W-1:0]         a_volt;
  logic [SAMPLE_W-1:0]         a_curr;
  logic [fmdt_pkg::DUTY_W-1:0] a_prev;
  logic                        a_ready;
  logic                        a_move;
  logic [POWER_W-1:0]          a_power;

  // Stage B: power and the two leaving samples from the history.
  logic                        b_valid;
  logic [POWER_W-1:0]          b_power;
  logic [fmdt_pkg::DUTY_W-1:0] b_prev;
  logic                        b_med_ok;
  logic                        b_fast_ok;
  logic                        b_ready;
  logic                        b_move;
  logic [POWER_W-1:0]          old_med;
  logic [POWER_W-1:0]          old_fast;

  logic [AW-1:0]               rd_ptr;
  logic [AW-1:0]               wr_ptr;
  logic [CNT_W-1:0]            fill_cnt;
  logic [AW:0]                 med_sum_addr;
  logic [AW:0]                 fast_sum_addr;
  logic [MSUM_W-1:0]           med_sum;
  logic [FSUM_W-1:0]           fast_sum;
  logic [MSUM_W-1:0]           med_sum_next;
  logic [FSUM_W-1:0]           fast_sum_next;

  assign b_ready      = !b_valid || sum_ready;
  assign b_move       = b_valid && sum_ready;
  assign a_ready      = !a_valid || b_ready;
  assign a_move       = a_valid && b_ready;
  assign sample_stall = !a_ready;

  assign a_power = POWER_W'(a_volt) * POWER_W'(a_curr);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && sample_valid) begin
      a_volt <= sample.voltage_sample[SAMPLE_W-1:0];
      a_curr <= sample.current_sample[SAMPLE_W-1:0];
      a_prev <= sample.duty_previous;
    end
  end

  // Slots of the samples that drop out of each window, one compare-subtract
  // to wrap around the ring.
  always_comb begin
    med_sum_addr  = {1'b0, rd_ptr} + MED_OFS;
    fast_sum_addr = {1'b0, rd_ptr} + FAST_OFS;
    if (med_sum_addr >= DEPTH_X) begin
      med_sum_addr = med_sum_addr - DEPTH_X;
    end
    if (fast_sum_addr >= DEPTH_X) begin
      fast_sum_addr = fast_sum_addr - DEPTH_X;
    end
  end

  assign hist_re         = a_move;
  assign hist_raddr_med  = med_sum_addr[AW-1:0];
  assign hist_raddr_fast = fast_sum_addr[AW-1:0];

  // The fill count stands in for a cleared history: before a window has
  // filled, the leaving sample counts as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr   <= '0;
      fill_cnt <= '0;
      b_valid  <= 1'b0;
    end else begin
      if (a_move) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
        if (fill_cnt != FULL) begin
          fill_cnt <= fill_cnt + 1'b1;
        end
      end
      if (b_ready) begin
        b_valid <= a_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_move) begin
      b_power   <= a_power;
      b_prev    <= a_prev;
      b_med_ok  <= (fill_cnt >= CNT_W'(MEDIUM_WINDOW));
      b_fast_ok <= (fill_cnt >= CNT_W'(FAST_WINDOW));
    end
  end

  assign old_med  = b_med_ok  ? hist_rdata_med  : '0;
  assign old_fast = b_fast_ok ? hist_rdata_fast : '0;

  assign med_sum_next  = MSUM_W'(({1'b0, med_sum} + (MSUM_W+1)'(b_power))
                                 - (MSUM_W+1)'(old_med));
  assign fast_sum_next = FSUM_W'(({1'b0, fast_sum} + (FSUM_W+1)'(b_power))
                                 - (FSUM_W+1)'(old_fast));

  assign hist_we    = b_move;
  assign hist_waddr = wr_ptr;
  assign hist_wdata = b_power;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      med_sum  <= '0;
      fast_sum <= '0;
    end else if (b_move) begin
      wr_ptr   <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      med_sum  <= med_sum_next;
      fast_sum <= fast_sum_next;
    end
  end

  assign sum_valid = b_valid;
  assign sum_prev  = b_prev;
  assign sum_med   = med_sum_next;
  assign sum_fast  = fast_sum_next;

endmodule

[rtl/fmdt_decide.sv]
// ---------------------------------------------------------------------------
// fmdt_decide
// Average comparison, reversal control and the saturated duty step.
// ---------------------------------------------------------------------------
module fmdt_decide #(
  parameter int MEDIUM_WINDOW = fmdt_pkg::MEDIUM_WINDOW_DEFAULT,
  parameter int FAST_WINDOW   = fmdt_pkg::FAST_WINDOW_DEFAULT,
  parameter int SAMPLE_BITS   = fmdt_pkg::SAMPLE_BITS_DEFAULT,
  localparam int SAMPLE_W = (SAMPLE_BITS < fmdt_pkg::VOLTAGE_W) ?
                            SAMPLE_BITS : fmdt_pkg::VOLTAGE_W,
  localparam int POWER_W  = 2 * SAMPLE_W,
  localparam int MSUM_W   = POWER_W + $clog2(MEDIUM_WINDOW),
  localparam int FSUM_W   = POWER_W + $clog2(FAST_WINDOW)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          sum_valid,
  output logic                          sum_ready,
  input  logic [fmdt_pkg::DUTY_W-1:0]   sum_prev,
  input  logic [MSUM_W-1:0]             sum_med,
  input  logic [FSUM_W-1:0]             sum_fast,
  input  fmdt_pkg::cfg_t                cfg,
  output logic                          result_valid,
  input  logic                          result_stall,
  output fmdt_pkg::result_t             result,
  output fmdt_pkg::state_t              dstate
);

  localparam int CMP_W = POWER_W + $clog2(MEDIUM_WINDOW + 1) + $clog2(FAST_WINDOW + 1);
  localparam int DW    = fmdt_pkg::DUTY_W;
  localparam int PW    = fmdt_pkg::PROD_W;

  // Stage C: window sums and the previous duty.
  logic              c_valid;
  logic [DW-1:0]     c_prev;
  logic [MSUM_W-1:0] c_med;
  logic [FSUM_W-1:0] c_fast;
  logic              c_ready;
  logic [CMP_W-1:0]  c_lhs;
  logic [CMP_W-1:0]  c_rhs;
  logic              c_gap_neg;
  logic [DW-1:0]     c_mag;
  logic [PW-1:0]     c_prod;

  // Stage D: scaled sums and the rounded step magnitude.
  logic              d_valid;
  logic [DW-1:0]     d_prev;
  logic [CMP_W-1:0]  d_lhs;
  logic [CMP_W-1:0]  d_rhs;
  logic              d_gap_neg;
  logic [DW-1:0]     d_rmag;
  logic              d_ready;
  logic              d_move;
  logic              flip;
  logic              going_up_next;
  logic              disarmed_next;
  logic              sub_step;
  logic signed [DW+1:0] duty_sum;
  logic [DW-1:0]     duty_sat;
  logic              out_ready;

  assign out_ready = !result_valid || !result_stall;
  assign d_ready   = !d_valid || out_ready;
  assign d_move    = d_valid && out_ready;
  assign c_ready   = !c_valid || d_ready;
  assign sum_ready = c_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid      <= 1'b0;
      d_valid      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (c_ready) begin
        c_valid <= sum_valid;
      end
      if (d_ready) begin
        d_valid <= c_valid;
      end
      if (out_ready) begin
        result_valid <= d_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (c_ready && sum_valid) begin
      c_prev <= sum_prev;
      c_med  <= sum_med;
      c_fast <= sum_fast;
    end
  end

  // Averages are compared exactly by cross-multiplying with the windows.
  assign c_lhs = CMP_W'(c_med)  * CMP_W'(FAST_WINDOW);
  assign c_rhs = CMP_W'(c_fast) * CMP_W'(MEDIUM_WINDOW);

  assign c_gap_neg = c_prev > cfg.duty_ceiling;
  assign c_mag     = c_gap_neg ? (c_prev - cfg.duty_ceiling) : (cfg.duty_ceiling - c_prev);
  assign c_prod    = PW'(c_mag) * PW'(cfg.step_fraction) + fmdt_pkg::ROUND_HALF;

  always_ff @(posedge clk) begin
    if (d_ready && c_valid) begin
      d_prev    <= c_prev;
      d_lhs     <= c_lhs;
      d_rhs     <= c_rhs;
      d_gap_neg <= c_gap_neg;
      d_rmag    <= c_prod[PW-1:fmdt_pkg::STEP_W];
    end
  end

  always_comb begin
    flip          = (d_lhs > d_rhs) && !dstate.disarmed;
    going_up_next = dstate.going_up ^ flip;
    disarmed_next = dstate.disarmed;
    if (flip) begin
      disarmed_next = 1'b1;
    end else if (d_lhs < d_rhs) begin
      disarmed_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dstate.going_up <= 1'b0;
      dstate.disarmed <= 1'b0;
    end else if (d_move) begin
      dstate.going_up <= going_up_next;
      dstate.disarmed <= disarmed_next;
    end
  end

  // Above the ceiling the gap is negative, which turns the move around.
  always_comb begin
    sub_step = (going_up_next == d_gap_neg);
    if (sub_step) begin
      duty_sum = $signed({2'b00, d_prev}) - $signed({2'b00, d_rmag});
    end else begin
      duty_sum = $signed({2'b00, d_prev}) + $signed({2'b00, d_rmag});
    end
    if (duty_sum < 0) begin
      duty_sat = '0;
    end else if (duty_sum > $signed({2'b00, fmdt_pkg::DUTY_MAX})) begin
      duty_sat = fmdt_pkg::DUTY_MAX;
    end else begin
      duty_sat = duty_sum[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (d_move) begin
      result.duty_next    <= duty_sat;
      result.direction_up <= going_up_next;
      result.reversed_now <= flip;
    end
  end

endmodule

[verif/tb_filtered_mppt_duty_tracker.sv]
// ---------------------------------------------------------------------------
// tb_filtered_mppt_duty_tracker: self-checking bench for the MPPT duty tracker
// Drives sample beats in random bursts against a receiver with its own stall
// pattern, predicts every result with an in-bench copy of the filter and the
// perturbation logic, and compares each result beat field by field. The
// registers are rewritten between phases, reaching the extremes of both.
// ---------------------------------------------------------------------------
module tb_filtered_mppt_duty_tracker;
  timeunit 1ns;
  timeprecision 1ps;

  import fmdt_pkg::*;

  localparam int CLK_HALF       = 4;
  localparam int RESET_CYCLES   = 5;
  localparam int RESULT_LATENCY = 4;
  localparam int CYCLE_LIMIT    = 400000;

  // Filter geometry, matching the parameters the block is built with.
  localparam int MED_WIN    = MEDIUM_WINDOW_DEFAULT;
  localparam int FAST_WIN   = FAST_WINDOW_DEFAULT;
  localparam int RING_DEPTH = (MED_WIN > FAST_WIN) ? MED_WIN : FAST_WIN;
  localparam int SAMPLE_MAX = (1 << VOLTAGE_W) - 1;
  localparam int DUTY_TOP   = (1 << DUTY_W) - 1;

  // Random part: one phase per register setting, a negative entry draws a
  // random value for that phase.
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 230;
  localparam int STEP_PLAN [PHASES] = '{65535, 0, 32768, 65535, 0, 33, 32768, -1};
  localparam int CEIL_PLAN [PHASES] = '{131071, 0, 79495, 0, 131071, 79495, -1, -1};

  // One row of the directed table. Rows with has_want set carry an
  // expectation typed in by hand; the rest are checked against the predictor.
  typedef struct packed {
    logic [VOLTAGE_W-1:0] voltage;
    logic [CURRENT_W-1:0] current;
    logic [DUTY_W-1:0]    duty_prev;
    logic                 has_want;
    result_t              want;
  } directed_row_t;

  localparam int DIRECTED_COUNT = 18;

  // The first four rows follow reset with the reset register values. The
  // fast and medium windows hold the same samples, so the medium average
  // never exceeds the fast one and the direction stays down (away from the
  // ceiling). Row 0: zero power, duty 0 pulled below zero and clamped.
  // Row 1: duty at the top, above the ceiling, so the move points up and
  // saturates. Row 2: duty exactly at the ceiling, no gap, no move. Row 3:
  // duty 1 moved down by 40 and clamped at zero.
  directed_row_t directed_rows [DIRECTED_COUNT] = '{
    '{12'd0,    12'd0,    17'd0,      1'b1, '{17'd0,      1'b0, 1'b0}},
    '{12'd4095, 12'd4095, 17'd131071, 1'b1, '{17'd131071, 1'b0, 1'b0}},
    '{12'd0,    12'd4095, 17'd79495,  1'b1, '{17'd79495,  1'b0, 1'b0}},
    '{12'd4095, 12'd0,    17'd1,      1'b1, '{17'd0,      1'b0, 1'b0}},
    '{12'd4095, 12'd4095, 17'd79496,  1'b0, '0},
    '{12'd4095, 12'd4095, 17'd79494,  1'b0, '0},
    '{12'hAAA,  12'h555,  17'h0AAAA,  1'b0, '0},
    '{12'h555,  12'hAAA,  17'h15555,  1'b0, '0},
    '{12'd1,    12'd1,    17'd1,      1'b0, '0},
    '{12'd4094, 12'd4094, 17'd131070, 1'b0, '0},
    '{12'd2048, 12'd2048, 17'd65536,  1'b0, '0},
    '{12'd1,    12'd4095, 17'd79497,  1'b0, '0},
    '{12'd4095, 12'd1,    17'd100000, 1'b0, '0},
    '{12'd0,    12'd0,    17'd131071, 1'b0, '0},
    '{12'h800,  12'h001,  17'h10000,  1'b0, '0},
    '{12'h7FF,  12'hFFE,  17'h0FFFF,  1'b0, '0},
    '{12'd12,   12'd34,   17'd40000,  1'b0, '0},
    '{12'd4095, 12'd4095, 17'd2,      1'b0, '0}
  };

  // Every input of the block starts at a known value.
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;
  logic sample_valid = 1'b0;
  logic sample_stall;
  sample_t sample = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_t result;

  filtered_mppt_duty_tracker DUT (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always #(CLK_HALF) clk = ~clk;

  // -------------------------------------------------------------------------
  // Predictor state: a private copy of the power history, both running sums,
  // the direction and the arming flag, and the two registers as last written.
  // The history starts at zero, which is what a masked, unfilled ring reads.
  // -------------------------------------------------------------------------
  logic [23:0]       power_ring [RING_DEPTH] = '{default: '0};
  int                ring_ptr = 0;
  logic [63:0]       medium_sum = '0;
  logic [63:0]       fast_sum = '0;
  logic              tracking_up = 1'b0;
  logic              flip_disarmed = 1'b0;
  logic [STEP_W-1:0] trk_step_fraction = STEP_FRACTION_RESET;
  logic [DUTY_W-1:0] trk_duty_ceiling = DUTY_CEILING_RESET;
  logic [DUTY_W-1:0] last_duty = '0;

  result_t duty_expect_q [$];
  int      error_count = 0;
  int      cycle_count = 0;

  // Works out the result beat that one accepted sample beat must produce and
  // advances the predictor state past that beat.
  function automatic result_t predict_duty(sample_t s);
    logic [23:0] power;
    logic [23:0] old_med;
    logic [23:0] old_fast;
    logic [63:0] lhs;
    logic [63:0] rhs;
    logic [63:0] mag;
    logic [63:0] rmag;
    logic        gap_neg;
    logic        subtract;
    logic        flipped;
    longint      nxt;
    result_t     r;

    power    = 24'(s.voltage_sample) * 24'(s.current_sample);
    old_med  = power_ring[(ring_ptr + RING_DEPTH - MED_WIN) % RING_DEPTH];
    old_fast = power_ring[(ring_ptr + RING_DEPTH - FAST_WIN) % RING_DEPTH];

    // Both sums take in the newest power and drop the one leaving the window.
    medium_sum = medium_sum + 64'(power) - 64'(old_med);
    fast_sum   = fast_sum + 64'(power) - 64'(old_fast);
    power_ring[ring_ptr] = power;
    ring_ptr = (ring_ptr + 1) % RING_DEPTH;

    // Averages are compared exactly by cross-multiplying with the windows.
    lhs = medium_sum * 64'(FAST_WIN);
    rhs = fast_sum * 64'(MED_WIN);
    flipped = 1'b0;
    if (lhs > rhs && !flip_disarmed) begin
      flip_disarmed = 1'b1;
      tracking_up   = ~tracking_up;
      flipped       = 1'b1;
    end
    if (lhs < rhs) begin
      flip_disarmed = 1'b0;
    end

    // Step is the gap to the ceiling times the fraction, rounded half up.
    // Above the ceiling the gap is negative, which turns the move around.
    gap_neg = s.duty_previous > trk_duty_ceiling;
    mag = gap_neg ? 64'(s.duty_previous) - 64'(trk_duty_ceiling)
                  : 64'(trk_duty_ceiling) - 64'(s.duty_previous);
    rmag = (mag * 64'(trk_step_fraction) + 64'd32768) >> 16;
    subtract = (tracking_up == gap_neg);
    nxt = subtract ? longint'(s.duty_previous) - longint'(rmag)
                   : longint'(s.duty_previous) + longint'(rmag);
    if (nxt < 0) begin
      nxt = 0;
    end
    if (nxt > DUTY_TOP) begin
      nxt = DUTY_TOP;
    end

    r.duty_next    = nxt[DUTY_W-1:0];
    r.direction_up = tracking_up;
    r.reversed_now = flipped;
    last_duty      = r.duty_next;
    return r;
  endfunction

  // Presents one sample beat and holds it until the block takes it. The
  // expectation is queued at the edge of acceptance: the hand-typed one for
  // directed rows that carry it, otherwise the predictor's.
  task automatic send_beat(sample_t s, logic has_want, result_t want);
    result_t predicted;
    sample_valid <= 1'b1;
    sample       <= s;
    do @(posedge clk); while (sample_stall);
    predicted = predict_duty(s);
    duty_expect_q.push_back(has_want ? want : predicted);
  endtask

  // Drops valid and waits until every queued result has come back. It always
  // waits on the clock before checking the queue, so the next beat never drives
  // valid twice in one time step.
  task automatic drain_results();
    sample_valid <= 1'b0;
    do @(posedge clk); while (duty_expect_q.size() != 0);
  endtask

  // Writes one register in a setup and an access cycle, then reads it back
  // in a second transfer that follows right after. Bits above the register
  // width carry random junk, which the block must ignore.
  task automatic write_reg(reg_index_t idx, int value);
    logic [APB_DATA_W-1:0] wd;
    logic [APB_DATA_W-1:0] mask;
    wd = $urandom();
    if (idx == REG_STEP_FRACTION) begin
      mask = APB_DATA_W'((1 << STEP_W) - 1);
    end else begin
      mask = APB_DATA_W'((1 << DUTY_W) - 1);
    end
    wd = (wd & ~mask) | (APB_DATA_W'(value) & mask);

    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= wd;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    // The write lands at this edge; the same select flows into the read.
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    if ((prdata & mask) !== (wd & mask)) begin
      $display("%0t: register %s readback expected 0x%0h got 0x%0h",
               $time, idx.name(), wd & mask, prdata & mask);
      error_count++;
    end
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);

    if (idx == REG_STEP_FRACTION) begin
      trk_step_fraction = wd[STEP_W-1:0];
    end else begin
      trk_duty_ceiling = wd[DUTY_W-1:0];
    end
  endtask

  // Random traffic. Power moves between levels that hold for tens to
  // hundreds of beats with a little noise, so the fast average falls below
  // and climbs back above the medium one and the direction really flips and
  // re-arms. A fifth of the beats are fully random. The previous duty is
  // half the time the last predicted duty, as in a closed loop, with the range
  // ends, the ceiling region and random values mixed in.
  task automatic run_random(int count);
    int      level_v;
    int      level_c;
    int      run_left;
    int      burst_left;
    int      gap;
    int      v;
    int      c;
    int      d;
    sample_t s;
    run_left   = 0;
    level_v    = 0;
    level_c    = 0;
    burst_left = $urandom_range(1, 60);
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) begin
        // Hold the sender off once per phase until the pipeline is empty.
        drain_results();
      end else if (burst_left == 0) begin
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          sample_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 60);
      end

      if (run_left == 0) begin
        level_v  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, SAMPLE_MAX);
        level_c  = $urandom_range(0, SAMPLE_MAX);
        run_left = $urandom_range(20, 300);
      end
      run_left--;

      if ($urandom_range(0, 9) < 2) begin
        v = $urandom_range(0, SAMPLE_MAX);
        c = $urandom_range(0, SAMPLE_MAX);
      end else begin
        v = level_v + $urandom_range(0, 16) - 8;
        c = level_c + $urandom_range(0, 16) - 8;
        v = (v < 0) ? 0 : (v > SAMPLE_MAX) ? SAMPLE_MAX : v;
        c = (c < 0) ? 0 : (c > SAMPLE_MAX) ? SAMPLE_MAX : c;
      end

      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: d = last_duty;
        5: d = 0;
        6: d = DUTY_TOP;
        7: begin
          d = int'(trk_duty_ceiling) + $urandom_range(0, 4) - 2;
          d = (d < 0) ? 0 : (d > DUTY_TOP) ? DUTY_TOP : d;
        end
        default: d = $urandom_range(0, DUTY_TOP);
      endcase

      s.voltage_sample = v[VOLTAGE_W-1:0];
      s.current_sample = c[CURRENT_W-1:0];
      s.duty_previous  = d[DUTY_W-1:0];
      send_beat(s, 1'b0, '0);
      burst_left--;
    end
  endtask

  // -------------------------------------------------------------------------
  // Receiver: the stall pattern switches at random between no stalls at
  // all, light and heavy random stalls, and long stall runs that back the
  // pipeline up into the sample side.
  // -------------------------------------------------------------------------
  int stall_mode = 0;
  int mode_left = 0;
  int stall_run_left = 0;

  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      mode_left  <= $urandom_range(50, 400);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      0: result_stall <= 1'b0;
      1: result_stall <= ($urandom_range(0, 3) == 0);
      2: result_stall <= ($urandom_range(0, 1) == 0);
      default: begin
        if (stall_run_left == 0) begin
          result_stall   <= ~result_stall;
          stall_run_left <= $urandom_range(1, 16);
        end else begin
          stall_run_left <= stall_run_left - 1;
        end
      end
    endcase
  end

  // -------------------------------------------------------------------------
  // Result checker. Values are read at the clock edge, before the block's
  // own updates of that edge, so a beat counts exactly when valid was high
  // and stall low going into the edge.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (duty_expect_q.size() == 0) begin
        $display("%0t: unexpected result beat duty=%0d up=%0b rev=%0b",
                 $time, result.duty_next, result.direction_up, result.reversed_now);
        error_count++;
      end else begin
        if (result.duty_next !== duty_expect_q[0].duty_next ||
            result.direction_up !== duty_expect_q[0].direction_up ||
            result.reversed_now !== duty_expect_q[0].reversed_now) begin
          $display("%0t: MISCOMPARE expected duty=%0d up=%0b rev=%0b actual duty=%0d up=%0b rev=%0b",
                   $time, duty_expect_q[0].duty_next, duty_expect_q[0].direction_up,
                   duty_expect_q[0].reversed_now, result.duty_next,
                   result.direction_up, result.reversed_now);
          error_count++;
        end
        void'(duty_expect_q.pop_front());
      end
    end
  end

  // Watchdog: a hung handshake or lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("filtered_mppt_duty_tracker: mismatch");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Main sequence: reset, the directed table with the reset register values,
  // then one random phase per register setting. Registers change only after
  // the pipeline has drained and its latency has passed.
  // -------------------------------------------------------------------------
  initial begin
    sample_t s;
    int      sf;
    int      ceil_val;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIRECTED_COUNT; i++) begin
      s.voltage_sample = directed_rows[i].voltage;
      s.current_sample = directed_rows[i].current;
      s.duty_previous  = directed_rows[i].duty_prev;
      send_beat(s, directed_rows[i].has_want, directed_rows[i].want);
    end

    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      repeat (RESULT_LATENCY + 2) @(posedge clk);
      sf       = (STEP_PLAN[p] < 0) ? $urandom_range(0, (1 << STEP_W) - 1) : STEP_PLAN[p];
      ceil_val = (CEIL_PLAN[p] < 0) ? $urandom_range(0, DUTY_TOP) : CEIL_PLAN[p];
      write_reg(REG_STEP_FRACTION, sf);
      write_reg(REG_DUTY_CEILING, ceil_val);
      run_random(ITEMS_PER_PHASE);
    end

    // Let the last results come home, then watch a while for strays.
    drain_results();
    repeat (RESULT_LATENCY * 4) @(posedge clk);
    if (duty_expect_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, duty_expect_q.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("filtered_mppt_duty_tracker: match");
    end else begin
      $display("filtered_mppt_duty_tracker: mismatch");
    end
    $finish;
  end

endmodule

[filtered_mppt_duty_tracker.f]
+incdir+rtl
rtl/fmdt_pkg.sv
rtl/fmdt_cfg_regs.sv
rtl/fmdt_history_mem.sv
rtl/fmdt_filter.sv
rtl/fmdt_decide.sv
rtl/filtered_mppt_duty_tracker.sv
verif/tb_filtered_mppt_duty_tracker.sv
